@@ src/gpbm_pkg.sv @@
// ----------------------------------------------------------------------------
// gpbm_pkg
// Shared types and codes of the greedy point-to-box matcher.
// ----------------------------------------------------------------------------
package gpbm_pkg;

  // action codes of a request
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_ADD   = 2'd1;
  localparam logic [1:0] ACT_MATCH = 2'd2;

  // status codes of a result
  localparam logic [1:0] ST_MATCHED     = 2'd0;
  localparam logic [1:0] ST_OUT_OF_VIEW = 2'd1;
  localparam logic [1:0] ST_NO_BOX      = 2'd2;

  // register indexes on the config port
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // widths
  localparam int DimW   = 13;  // image size registers
  localparam int CtrW   = 13;  // doubled box center
  localparam int P2W    = 15;  // doubled point coordinate
  localparam int DistW  = 30;  // squared distance of doubled coordinates
  localparam int IdxW   = 8;   // cell index, enough for 256 cells
  localparam int LabelW = 16;

  typedef struct packed {
    logic [1:0]        action;
    logic [11:0]       box_min_x;
    logic [11:0]       box_max_x;
    logic [11:0]       box_min_y;
    logic [11:0]       box_max_y;
    logic [15:0]       box_label;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic              in_front;
    logic [15:0]       point_tag;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] matched_label;
    logic [4:0]  matched_index;
    logic [15:0] result_tag;
  } res_t;

  // one stored box
  typedef struct packed {
    logic [CtrW-1:0]   c2x;
    logic [CtrW-1:0]   c2y;
    logic [LabelW-1:0] label;
  } box_t;

  // doubled query point, broadcast to every cell
  typedef struct packed {
    logic [P2W-1:0] p2x;
    logic [P2W-1:0] p2y;
  } point_t;

  // best-so-far token walking down the chain
  typedef struct packed {
    logic              active;
    logic              found;
    logic [DistW-1:0]  sq_dist;
    logic [LabelW-1:0] label;
    logic [IdxW-1:0]   idx;
  } token_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic clear;   // start of frame, drop used mark
    logic write;   // store the broadcast box here
    logic mark;    // this cell won the scan
    logic filled;  // holds a box of the current frame
  } cell_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

endpackage

@@ src/gpbm_cell.sv @@
// ----------------------------------------------------------------------------
// gpbm_cell
// One table slot: holds a box and its used mark, updates the passing token.
// ----------------------------------------------------------------------------
module gpbm_cell #(
  parameter int CELL_INDEX = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  gpbm_pkg::cell_ctl_t ctl,
  input  gpbm_pkg::box_t      wr_box,
  input  gpbm_pkg::point_t    pt,
  input  gpbm_pkg::token_t    tok_in,
  output gpbm_pkg::token_t    tok_out
);

  gpbm_pkg::box_t   box;
  logic             used;
  gpbm_pkg::token_t tok_next;

  logic signed [15:0] dx;
  logic signed [15:0] dy;
  logic signed [31:0] dx_sq;
  logic signed [31:0] dy_sq;
  logic [gpbm_pkg::DistW:0]   dsum;
  logic [gpbm_pkg::DistW-1:0] sq_dist;
  logic                       take;

  always_comb begin
    dx    = signed'({3'b000, box.c2x}) - signed'({1'b0, pt.p2x});
    dy    = signed'({3'b000, box.c2y}) - signed'({1'b0, pt.p2y});
    dx_sq = dx * dx;
    dy_sq = dy * dy;
    dsum  = {1'b0, dx_sq[gpbm_pkg::DistW-1:0]} + {1'b0, dy_sq[gpbm_pkg::DistW-1:0]};
    sq_dist = dsum[gpbm_pkg::DistW-1:0];
    // strict less keeps the lower index on ties
    take  = tok_in.active && ctl.filled && !used &&
            (!tok_in.found || sq_dist < tok_in.sq_dist);
    tok_next = tok_in;
    if (take) begin
      tok_next.found   = 1'b1;
      tok_next.sq_dist = sq_dist;
      tok_next.label   = box.label;
      tok_next.idx     = gpbm_pkg::IdxW'(CELL_INDEX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used           <= 1'b0;
      tok_out.active <= 1'b0;
    end else begin
      if (ctl.clear || ctl.write) begin
        used <= 1'b0;
      end else if (ctl.mark) begin
        used <= 1'b1;
      end
      tok_out.active <= tok_next.active;
    end
    if (ctl.write) begin
      box <= wr_box;
    end
    tok_out.found   <= tok_next.found;
    tok_out.sq_dist <= tok_next.sq_dist;
    tok_out.label   <= tok_next.label;
    tok_out.idx     <= tok_next.idx;
  end

endmodule

@@ src/greedy_point_to_box_matcher.sv @@
// ----------------------------------------------------------------------------
// greedy_point_to_box_matcher
// Greedy nearest-box assignment of projected points over a chain of box cells.
// ----------------------------------------------------------------------------
//
//  channel  | signals                          | moves
//  ---------+----------------------------------+-------------------------------
//  request  | req_valid, req_ready, req        | start / add box / match point
//  result   | res_valid, res_ready, res        | one per match request
//  config   | psel penable pwrite paddr pwdata | image_width, image_height
//           | prdata pready                    |
//
//  start and add requests leave the sequencer idle; an out-of-view match goes
//  straight to finish, a scanned match through scan and finish: the best-so-far
//  token walks one cell per cycle down the chain, then the result is handed over
//  reset clears the used marks, box count, sequencer and result valid
//  a stalled result stays in the output register; the next request is taken
//  while it waits, and a new result waits in the finish state until it drains
//
module greedy_point_to_box_matcher #(
  parameter int MAX_BOXES = 32
) (
  input  logic              clk,
  input  logic              rst,
  // request channel
  input  logic              req_valid,
  output logic              req_ready,
  input  gpbm_pkg::req_t    req,
  // result channel
  output logic              res_valid,
  input  logic              res_ready,
  output gpbm_pkg::res_t    res,
  // config port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int CntW = $clog2(MAX_BOXES + 1);

  // config registers
  logic [gpbm_pkg::DimW-1:0] image_width;
  logic [gpbm_pkg::DimW-1:0] image_height;
  logic                      cfg_wr;

  // sequencer
  gpbm_pkg::state_t state;
  gpbm_pkg::state_t state_next;
  logic             req_fire;
  logic             load_out;

  // frame table control
  logic [CntW-1:0]  box_count;
  logic             in_view;
  logic             is_start;
  logic             is_add;
  logic             is_match;

  // scan datapath
  gpbm_pkg::point_t    pt;
  gpbm_pkg::box_t      wr_box;
  gpbm_pkg::token_t    tok [MAX_BOXES+1];
  gpbm_pkg::token_t    tok_head;
  gpbm_pkg::token_t    tail;
  gpbm_pkg::cell_ctl_t ctl [MAX_BOXES];
  logic [MAX_BOXES-1:0] mark_vec;

  // pending result
  gpbm_pkg::res_t  pend;
  logic [15:0]     tag;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= gpbm_pkg::DimW'(640);
      image_height <= gpbm_pkg::DimW'(480);
    end else if (cfg_wr) begin
      case (paddr[2])
        gpbm_pkg::REG_IMAGE_WIDTH:  image_width  <= pwdata[gpbm_pkg::DimW-1:0];
        gpbm_pkg::REG_IMAGE_HEIGHT: image_height <= pwdata[gpbm_pkg::DimW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      gpbm_pkg::REG_IMAGE_WIDTH:  prdata = {{(32-gpbm_pkg::DimW){1'b0}}, image_width};
      gpbm_pkg::REG_IMAGE_HEIGHT: prdata = {{(32-gpbm_pkg::DimW){1'b0}}, image_height};
      default:                    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------- request decode
  assign req_fire = req_valid && req_ready;
  assign is_start = req_fire && (req.action == gpbm_pkg::ACT_START);
  assign is_add   = req_fire && (req.action == gpbm_pkg::ACT_ADD);
  assign is_match = req_fire && (req.action == gpbm_pkg::ACT_MATCH);

  // in front, sign bit clear and below the image size on both axes
  assign in_view = req.in_front &&
                   !req.point_x[15] && (req.point_x[14:0] < {2'b00, image_width}) &&
                   !req.point_y[15] && (req.point_y[14:0] < {2'b00, image_height});

  // doubled centers stay exact: min + max
  assign wr_box.c2x   = {1'b0, req.box_min_x} + {1'b0, req.box_max_x};
  assign wr_box.c2y   = {1'b0, req.box_min_y} + {1'b0, req.box_max_y};
  assign wr_box.label = req.box_label;

  // box count: start empties the table, adds past the end are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      box_count <= '0;
    end else if (is_start) begin
      box_count <= '0;
    end else if (is_add && (box_count < CntW'(MAX_BOXES))) begin
      box_count <= box_count + 1'b1;
    end
  end

  // ---------------------------------------------------------- sequencer
  always_comb begin
    state_next = state;
    case (state)
      gpbm_pkg::S_IDLE: begin
        if (is_match) begin
          state_next = in_view ? gpbm_pkg::S_SCAN : gpbm_pkg::S_FINISH;
        end
      end
      gpbm_pkg::S_SCAN: begin
        if (tail.active) begin
          state_next = gpbm_pkg::S_FINISH;
        end
      end
      gpbm_pkg::S_FINISH: begin
        if (!res_valid || res_ready) begin
          state_next = gpbm_pkg::S_IDLE;
        end
      end
      default: state_next = gpbm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req_ready = (state == gpbm_pkg::S_IDLE);
    load_out  = (state == gpbm_pkg::S_FINISH) && (!res_valid || res_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gpbm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------- token launch
  // the token is registered from the accepted match and enters cell 0 in the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_head.active <= 1'b0;
    end else begin
      tok_head.active <= is_match && in_view;
    end
    tok_head.found   <= 1'b0;
    tok_head.sq_dist <= '0;
    tok_head.label   <= '0;
    tok_head.idx     <= '0;
    if (is_match) begin
      pt.p2x <= {req.point_x[13:0], 1'b0};
      pt.p2y <= {req.point_y[13:0], 1'b0};
      tag    <= req.point_tag;
    end
  end

  assign tok[0] = tok_head;
  assign tail   = tok[MAX_BOXES];

  // ---------------------------------------------------------- cell chain
  for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
    always_comb begin
      ctl[i].clear  = is_start;
      ctl[i].write  = is_add && (box_count == CntW'(i));
      ctl[i].mark   = (state == gpbm_pkg::S_SCAN) && tail.active && tail.found &&
                      (tail.idx == gpbm_pkg::IdxW'(i));
      ctl[i].filled = (CntW'(i) < box_count);
    end
    assign mark_vec[i] = ctl[i].mark;

    gpbm_cell #(
      .CELL_INDEX (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl[i]),
      .wr_box  (wr_box),
      .pt      (pt),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  // ---------------------------------------------------------- result
  // pending result is built when the token leaves the chain or at once
  // for a point out of view
  always_ff @(posedge clk) begin
    if (is_match && !in_view) begin
      pend.status        <= gpbm_pkg::ST_OUT_OF_VIEW;
      pend.matched_label <= '0;
      pend.matched_index <= '0;
      pend.result_tag    <= req.point_tag;
    end else if ((state == gpbm_pkg::S_SCAN) && tail.active) begin
      pend.result_tag <= tag;
      if (tail.found) begin
        pend.status        <= gpbm_pkg::ST_MATCHED;
        pend.matched_label <= tail.label;
        pend.matched_index <= tail.idx[4:0];
      end else begin
        pend.status        <= gpbm_pkg::ST_NO_BOX;
        pend.matched_label <= '0;
        pend.matched_index <= '0;
      end
    end
  end

  // output register parts the result side from the scan
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_out) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res <= pend;
    end
  end

  // ---------------------------------------------------------- assertions
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    box_count <= CntW'(MAX_BOXES))
    else $error("box count beyond table size");

  a_tail_in_scan: assert property (@(posedge clk) disable iff (rst)
    tail.active |-> (state == gpbm_pkg::S_SCAN))
    else $error("token left the chain outside a scan");

  a_single_mark: assert property (@(posedge clk) disable iff (rst)
    $onehot0(mark_vec))
    else $error("more than one cell marked used");

  a_found_filled: assert property (@(posedge clk) disable iff (rst)
    (tail.active && tail.found) |-> (tail.idx < gpbm_pkg::IdxW'(box_count)))
    else $error("winner outside the filled table");

  a_scan_result: assert property (@(posedge clk) disable iff (rst)
    ((state == gpbm_pkg::S_SCAN) && tail.active && tail.found) |=>
      (pend.status == gpbm_pkg::ST_MATCHED) && (state == gpbm_pkg::S_FINISH))
    else $error("found winner did not produce a matched result");

endmodule

@@ tb/tb_greedy_point_to_box_matcher.sv @@
// ----------------------------------------------------------------------------
// tb_greedy_point_to_box_matcher
// Self-checking bench for the greedy point-to-box matcher. A short list of
// directed requests covers field extremes, view boundaries, inverted and
// duplicate boxes and empty tables. Random frames follow (start, adds, matches)
// under several image sizes written over the config port. Every result is checked
// field by field against a typed-in value or a bench-side model of the box table.
// ----------------------------------------------------------------------------
module tb_greedy_point_to_box_matcher;

  localparam int MAX_BOXES     = 32;
  localparam int SETTLE_CYCLES = MAX_BOXES + 8;  // longer than a full scan
  localparam int LONG_HOLD     = 300;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int ITEM_TARGET   = 1850;
  localparam int PHASES        = 7;
  localparam int PRINT_LIMIT   = 40;

  // action code that the block ignores
  localparam logic [1:0] ACT_NONE = 2'd3;

  // image size per phase, -1 picks a random size, phase 0 keeps reset values
  localparam int PHASE_WIDTH  [PHASES] = '{640, 0, 8191, 1, 4096, -1, 640};
  localparam int PHASE_HEIGHT [PHASES] = '{480, 4096, 8191, 1, 0, -1, 480};

  logic           clk;
  logic           rst;
  logic           req_valid;
  logic           req_ready;
  gpbm_pkg::req_t req;
  logic           res_valid;
  logic           res_ready;
  gpbm_pkg::res_t res;
  logic           psel;
  logic           penable;
  logic           pwrite;
  logic [2:0]     paddr;
  logic [31:0]    pwdata;
  logic [31:0]    prdata;
  logic           pready;

  greedy_point_to_box_matcher #(
    .MAX_BOXES (MAX_BOXES)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // one directed request, with its result typed in where it is obvious
  typedef struct {
    gpbm_pkg::req_t item;
    bit             typed;
    gpbm_pkg::res_t outcome;
  } stim_row_t;

  // bench copy of the box table and the image size
  logic [12:0]          view_width;
  logic [12:0]          view_height;
  logic [12:0]          box_cx2   [MAX_BOXES];
  logic [12:0]          box_cy2   [MAX_BOXES];
  logic [15:0]          box_lbl   [MAX_BOXES];
  logic [MAX_BOXES-1:0] box_taken;
  int                   boxes_held;

  gpbm_pkg::res_t expected_assignments [$];
  stim_row_t      directed_rows [$];
  gpbm_pkg::res_t oldest;
  gpbm_pkg::req_t last_add;
  int        mismatch_count  = 0;
  int        requests_sent   = 0;
  int        cycle_count     = 0;
  int        holds_requested = 0;
  int        holds_done      = 0;
  bit        no_gaps         = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ------------------------------------------------------------------------
  // model of the block: updates the table, returns 1 when a result is due
  // ------------------------------------------------------------------------
  function automatic bit predict_assignment(input gpbm_pkg::req_t r,
                                            output gpbm_pkg::res_t outcome);
    longint px, py, dx, dy, sq_dist, best;
    int     win, i;
    bit     found;
    outcome            = '0;
    outcome.result_tag = r.point_tag;
    found              = 1'b0;
    best               = 0;
    win                = 0;
    case (r.action)
      gpbm_pkg::ACT_START: begin
        box_taken  = '0;
        boxes_held = 0;
        return 1'b0;
      end
      gpbm_pkg::ACT_ADD: begin
        // a full table drops the box, inverted edges are taken as they are
        if (boxes_held < MAX_BOXES) begin
          box_cx2[boxes_held]   = {1'b0, r.box_min_x} + {1'b0, r.box_max_x};
          box_cy2[boxes_held]   = {1'b0, r.box_min_y} + {1'b0, r.box_max_y};
          box_lbl[boxes_held]   = r.box_label;
          box_taken[boxes_held] = 1'b0;
          boxes_held++;
        end
        return 1'b0;
      end
      gpbm_pkg::ACT_MATCH: ;
      default: return 1'b0;
    endcase
    px             = $signed(r.point_x);
    py             = $signed(r.point_y);
    outcome.status = gpbm_pkg::ST_OUT_OF_VIEW;
    if (r.in_front && px >= 0 && py >= 0 &&
        px < longint'(view_width) && py < longint'(view_height)) begin
      // doubled point against doubled centers keeps the distance order
      for (i = 0; i < boxes_held; i++) begin
        if (!box_taken[i]) begin
          dx      = longint'(box_cx2[i]) - 2 * px;
          dy      = longint'(box_cy2[i]) - 2 * py;
          sq_dist = dx * dx + dy * dy;
          // strict less keeps the lowest index on ties
          if (!found || sq_dist < best) begin
            found = 1'b1;
            best  = sq_dist;
            win   = i;
          end
        end
      end
      if (found) begin
        box_taken[win]         = 1'b1;
        outcome.status         = gpbm_pkg::ST_MATCHED;
        outcome.matched_label  = box_lbl[win];
        outcome.matched_index  = win[4:0];
      end else begin
        outcome.status = gpbm_pkg::ST_NO_BOX;
      end
    end
    return 1'b1;
  endfunction

  // ------------------------------------------------------------------------
  // request builders
  // ------------------------------------------------------------------------
  function automatic gpbm_pkg::req_t random_req(input logic [1:0] action);
    logic [127:0]   raw;
    gpbm_pkg::req_t r;
    raw      = {$urandom(), $urandom(), $urandom(), $urandom()};
    r        = raw[$bits(gpbm_pkg::req_t)-1:0];
    r.action = action;
    return r;
  endfunction

  function automatic gpbm_pkg::req_t add_req(input int mnx, input int mxx, input int mny,
                                             input int mxy, input int lbl);
    gpbm_pkg::req_t r;
    r           = random_req(gpbm_pkg::ACT_ADD);
    r.box_min_x = 12'(mnx);
    r.box_max_x = 12'(mxx);
    r.box_min_y = 12'(mny);
    r.box_max_y = 12'(mxy);
    r.box_label = 16'(lbl);
    return r;
  endfunction

  function automatic gpbm_pkg::req_t match_req(input int px, input int py,
                                               input bit front, input int tag);
    gpbm_pkg::req_t r;
    r           = random_req(gpbm_pkg::ACT_MATCH);
    r.point_x   = 16'(px);
    r.point_y   = 16'(py);
    r.in_front  = front;
    r.point_tag = 16'(tag);
    return r;
  endfunction

  function automatic stim_row_t row(input gpbm_pkg::req_t r, input bit typed,
                                    input logic [1:0] st);
    stim_row_t s;
    s.item               = r;
    s.typed              = typed;
    s.outcome            = '0;
    s.outcome.status     = st;
    s.outcome.result_tag = r.point_tag;
    return s;
  endfunction

  task automatic enqueue_row(input stim_row_t s);
    directed_rows.insert(directed_rows.size(), s);
  endtask

  // coordinate mostly inside the image, sometimes on its border or anywhere
  function automatic logic [15:0] pick_coord(input logic [12:0] size);
    int v;
    case ($urandom_range(0, 9))
      0: v = $urandom_range(0, 65535);
      1: begin
        case ($urandom_range(0, 3))
          0:       v = -1;
          1:       v = 0;
          2:       v = int'(size) - 1;
          default: v = int'(size);
        endcase
      end
      default: v = (size == 0) ? 0 : $urandom_range(0, int'(size) - 1);
    endcase
    return v[15:0];
  endfunction

  // box extent on one axis, now and then inverted or spread over all 12 bits
  task automatic pick_span(input logic [12:0] size, output logic [11:0] lo,
                           output logic [11:0] hi);
    int lim, a, b;
    lim = (size == 0 || size > 4096 || $urandom_range(0, 3) == 0) ? 4095 : int'(size) - 1;
    a   = $urandom_range(0, lim);
    b   = $urandom_range(a, lim);
    if ($urandom_range(0, 7) == 0) begin
      lo = 12'(b);
      hi = 12'(a);
    end else begin
      lo = 12'(a);
      hi = 12'(b);
    end
  endtask

  function automatic gpbm_pkg::req_t random_match();
    gpbm_pkg::req_t r;
    r          = random_req(gpbm_pkg::ACT_MATCH);
    r.point_x  = pick_coord(view_width);
    r.point_y  = pick_coord(view_height);
    r.in_front = ($urandom_range(0, 7) != 0);
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // request side: gap, offer, hold until taken, then predict
  // ------------------------------------------------------------------------
  task automatic offer_request(input gpbm_pkg::req_t r, input bit typed,
                               input gpbm_pkg::res_t typed_res);
    int             gap;
    gpbm_pkg::res_t predicted;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (req_ready !== 1'b1);
    if (predict_assignment(r, predicted))
      expected_assignments.insert(expected_assignments.size(), typed ? typed_res : predicted);
    if (r.action != ACT_NONE)
      requests_sent++;
    @(negedge clk);
  endtask

  // one frame: usually a start, some adds, then matches
  task automatic random_frame();
    gpbm_pkg::req_t r;
    int             n_add, n_match, k;
    no_gaps = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 9) != 0)
      offer_request(random_req(gpbm_pkg::ACT_START), 1'b0, '0);
    // now and then more boxes than the table holds
    n_add = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 10);
    for (k = 0; k < n_add; k++) begin
      if (k != 0 && $urandom_range(0, 5) == 0) begin
        // same box again, so distances tie
        r           = last_add;
        r.box_label = 16'($urandom());
      end else begin
        r = random_req(gpbm_pkg::ACT_ADD);
        pick_span(view_width, r.box_min_x, r.box_max_x);
        pick_span(view_height, r.box_min_y, r.box_max_y);
      end
      last_add = r;
      offer_request(r, 1'b0, '0);
      if ($urandom_range(0, 19) == 0)
        offer_request(random_req(ACT_NONE), 1'b0, '0);
    end
    n_match = $urandom_range(0, (n_add > 30) ? 36 : n_add + 2);
    for (k = 0; k < n_match; k++)
      offer_request(random_match(), 1'b0, '0);
  endtask

  // ------------------------------------------------------------------------
  // config port and idle handling
  // ------------------------------------------------------------------------
  task automatic write_register(input logic which, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {which, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (which == gpbm_pkg::REG_IMAGE_WIDTH)
      view_width = value[12:0];
    else
      view_height = value[12:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // all results in, then room for a scan started by the last request
  task automatic wait_idle();
    req_valid <= 1'b0;
    while (expected_assignments.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // ------------------------------------------------------------------------
  // result side
  // ------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < PRINT_LIMIT)
      $display("mismatch %s: got %0h want %0h (cycle %0d)", what, got, want, cycle_count);
    mismatch_count++;
  endtask

  // ready drops for a random gap per result, or for a long hold on request
  initial begin : result_sink
    int gap;
    res_ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (holds_done != holds_requested) begin
        gap = LONG_HOLD;
        holds_done++;
      end else begin
        gap = no_gaps ? 0 : $urandom_range(0, 3);
      end
      if (gap != 0) begin
        res_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      res_ready <= 1'b1;
      do @(posedge clk); while (!(res_valid === 1'b1 && res_ready === 1'b1));
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst === 1'b0 && res_valid === 1'b1 && res_ready === 1'b1) begin
      if (expected_assignments.size() == 0) begin
        report_mismatch("result with nothing pending, tag", 32'(res.result_tag), 0);
      end else begin
        oldest = expected_assignments.pop_front();
        if (res.status !== oldest.status)
          report_mismatch("status", 32'(res.status), 32'(oldest.status));
        if (res.matched_label !== oldest.matched_label)
          report_mismatch("matched_label", 32'(res.matched_label),
                          32'(oldest.matched_label));
        if (res.matched_index !== oldest.matched_index)
          report_mismatch("matched_index", 32'(res.matched_index),
                          32'(oldest.matched_index));
        if (res.result_tag !== oldest.result_tag)
          report_mismatch("result_tag", 32'(res.result_tag), 32'(oldest.result_tag));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------------
  initial begin : main_flow
    int          phase, i;
    logic [12:0] w, h;
    rst         = 1'b1;
    req_valid   = 1'b0;
    req         = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    view_width  = 13'd640;
    view_height = 13'd480;
    box_taken   = '0;
    boxes_held  = 0;
    last_add    = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // empty table after reset, then not in front
    enqueue_row(row(match_req(100, 100, 1'b1, 16'hFFFF), 1'b1, gpbm_pkg::ST_NO_BOX));
    enqueue_row(row(match_req(100, 100, 1'b0, 16'h0000), 1'b1, gpbm_pkg::ST_OUT_OF_VIEW));
    enqueue_row(row(random_req(gpbm_pkg::ACT_START), 1'b0, gpbm_pkg::ST_MATCHED));
    // extreme, inverted and duplicated boxes
    enqueue_row(row(add_req(0, 0, 0, 0, 16'h0000), 1'b0, gpbm_pkg::ST_MATCHED));
    enqueue_row(row(add_req(4095, 4095, 4095, 4095, 16'hFFFF), 1'b0, gpbm_pkg::ST_MATCHED));
    enqueue_row(row(add_req(4095, 0, 4095, 0, 16'h1234), 1'b0, gpbm_pkg::ST_MATCHED));
    enqueue_row(row(add_req(100, 120, 50, 70, 16'hA5A5), 1'b0, gpbm_pkg::ST_MATCHED));
    enqueue_row(row(add_req(100, 120, 50, 70, 16'h5A5A), 1'b0, gpbm_pkg::ST_MATCHED));
    // view boundaries and extreme coordinates
    enqueue_row(row(match_req(-1, 10, 1'b1, 1), 1'b1, gpbm_pkg::ST_OUT_OF_VIEW));
    enqueue_row(row(match_req(-32768, 32767, 1'b1, 2), 1'b1, gpbm_pkg::ST_OUT_OF_VIEW));
    enqueue_row(row(match_req(640, 0, 1'b1, 3), 1'b1, gpbm_pkg::ST_OUT_OF_VIEW));
    enqueue_row(row(match_req(0, 480, 1'b1, 4), 1'b1, gpbm_pkg::ST_OUT_OF_VIEW));
    enqueue_row(row(match_req(32767, -32768, 1'b1, 5), 1'b1, gpbm_pkg::ST_OUT_OF_VIEW));
    // tie at the duplicated box, then its twin
    enqueue_row(row(match_req(110, 60, 1'b1, 6), 1'b0, gpbm_pkg::ST_MATCHED));
    enqueue_row(row(match_req(110, 60, 1'b1, 7), 1'b0, gpbm_pkg::ST_MATCHED));
    enqueue_row(row(random_req(ACT_NONE), 1'b0, gpbm_pkg::ST_MATCHED));
    enqueue_row(row(match_req(639, 479, 1'b1, 8), 1'b0, gpbm_pkg::ST_MATCHED));
    enqueue_row(row(match_req(0, 0, 1'b1, 9), 1'b0, gpbm_pkg::ST_MATCHED));
    enqueue_row(row(match_req(320, 240, 1'b1, 10), 1'b0, gpbm_pkg::ST_MATCHED));
    // all five boxes taken
    enqueue_row(row(match_req(0, 0, 1'b1, 11), 1'b1, gpbm_pkg::ST_NO_BOX));
    enqueue_row(row(random_req(gpbm_pkg::ACT_START), 1'b0, gpbm_pkg::ST_MATCHED));
    enqueue_row(row(match_req(0, 0, 1'b1, 12), 1'b1, gpbm_pkg::ST_NO_BOX));
    enqueue_row(row(add_req(10, 20, 10, 20, 16'h0001), 1'b0, gpbm_pkg::ST_MATCHED));
    enqueue_row(row(match_req(15, 15, 1'b1, 16'h8000), 1'b0, gpbm_pkg::ST_MATCHED));

    for (i = 0; i < directed_rows.size(); i++)
      offer_request(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].outcome);

    for (phase = 0; phase < PHASES; phase++) begin
      if (phase != 0) begin
        wait_idle();
        w = (PHASE_WIDTH[phase] < 0) ? 13'($urandom_range(1, 4096)) : 13'(PHASE_WIDTH[phase]);
        h = (PHASE_HEIGHT[phase] < 0) ? 13'($urandom_range(1, 4096))
                                      : 13'(PHASE_HEIGHT[phase]);
        write_register(gpbm_pkg::REG_IMAGE_WIDTH, {19'd0, w});
        write_register(gpbm_pkg::REG_IMAGE_HEIGHT, {19'd0, h});
      end
      if (phase == PHASES - 1) begin
        // sink stalls long after its next result while matches keep coming
        no_gaps = 1'b1;
        holds_requested++;
        repeat (12) offer_request(random_match(), 1'b0, '0);
      end
      while (requests_sent < (phase + 1) * ITEM_TARGET / PHASES)
        random_frame();
    end

    wait_idle();
    if (mismatch_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

@@ greedy_point_to_box_matcher.f @@
src/gpbm_pkg.sv
src/gpbm_cell.sv
src/greedy_point_to_box_matcher.sv
tb/tb_greedy_point_to_box_matcher.sv
